// ----- rtl/address_range_sort_merge_assert.svh -----
// Assertion macros for the address range sort and merge block.
// Used by the port checker; needs clk and rst in the including scope.
`ifndef ADDRESS_RANGE_SORT_MERGE_ASSERT_SVH
`define ADDRESS_RANGE_SORT_MERGE_ASSERT_SVH

// implication checked in the same cycle
`define ARSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define ARSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/arsm_pkg.sv -----
// Shared types and constants for the address range sort and merge block.
// No dependencies.
`timescale 1ns / 1ps

package arsm_pkg;

  localparam int FIELD_BITS = 32;

  typedef struct packed {
    logic a_lt_b;
    logic a_eq_b;
    logic a_touch_b;
    logic c_gt_d;
    logic a_gt_p;
  } cmp_res_t;

endpackage

// ----- rtl/arsm_store.sv -----
// Range store: start and end memories, one write port, one registered read port.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module arsm_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [AW-1:0]            wr_start,
  input  logic [AW-1:0]            wr_end,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [AW-1:0]            rd_start,
  output logic [AW-1:0]            rd_end
);

  logic [AW-1:0] start_mem [DEPTH];
  logic [AW-1:0] end_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
      end_mem[wr_addr]   <= wr_end;
    end
  end

  always_ff @(posedge clk) begin
    rd_start <= start_mem[rd_addr];
    rd_end   <= end_mem[rd_addr];
  end

endmodule

// ----- rtl/arsm_cmp.sv -----
// Shared compare unit: ordering, equality and non-wrapping adjacency tests.
// Depends on arsm_pkg for the result struct.
`timescale 1ns / 1ps

module arsm_cmp #(
  parameter int AW = 32
) (
  input  logic [AW-1:0]       op_a,
  input  logic [AW-1:0]       op_b,
  input  logic [AW-1:0]       op_c,
  input  logic [AW-1:0]       op_d,
  input  logic [AW-1:0]       op_p,
  output arsm_pkg::cmp_res_t  res
);

  logic [AW:0] b_inc;

  assign b_inc = {1'b0, op_b} + (AW+1)'(1);

  always_comb begin
    res.a_lt_b    = op_a < op_b;
    res.a_eq_b    = op_a == op_b;
    res.a_touch_b = {1'b0, op_a} == b_inc;
    res.c_gt_d    = op_c > op_d;
    res.a_gt_p    = op_a > op_p;
  end

endmodule

// ----- rtl/address_range_sort_merge.sv -----
// Top level: loads ranges, then selects them in start order and merges them.
// Depends on arsm_pkg, arsm_store and arsm_cmp.
//
//  channel | signals                                         | role
//  input   | in_valid, in_stall, range_start, range_end,     | one range per transaction
//          | is_last                                         |
//  output  | out_valid, out_stall, merged_start, merged_end, | one merged range per transaction
//          | last_of_run, overflow                           |
//
// Loading accepts one range per cycle. After the last range, n stored ranges take one
// selection pass per distinct start plus a closing one (at most n + 1); each pass scans
// the store through its single read port and the shared compare unit.
// The input stalls from the last range until the final merged range is registered.
// A stalled output holds each merge step until the waiting result is taken.
// Reset is synchronous and clears the fill count, the dropped flag behind overflow, the sequencer and out_valid.
`timescale 1ns / 1ps

module address_range_sort_merge #(
  parameter int MAX_RANGES   = 32,
  parameter int ADDRESS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] merged_start,
  output logic [31:0] merged_end,
  output logic        last_of_run,
  output logic        overflow
);

  localparam int FW = arsm_pkg::FIELD_BITS;
  localparam int AW = (ADDRESS_BITS < FW) ? ADDRESS_BITS : FW;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = $clog2(MAX_RANGES);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_STEP = 3'b100
  } state_t;

  state_t             state;
  logic [CW-1:0]      fill_count;
  logic               dropped;
  logic [CW-1:0]      idx;
  logic               rd_vld;
  logic               found;
  logic [AW-1:0]      best_s;
  logic [AW-1:0]      best_e;
  logic               have_prev;
  logic [AW-1:0]      prev_s;
  logic               have_cur;
  logic [AW-1:0]      cur_s;
  logic [AW-1:0]      cur_e;

  logic               full;
  logic               accept;
  logic               wr_en;
  logic               out_free;
  logic               joins;
  logic               emit;
  logic [AW-1:0]      rd_s;
  logic [AW-1:0]      rd_e;
  logic [AW-1:0]      op_a;
  logic [AW-1:0]      op_b;
  logic [AW-1:0]      op_c;
  logic [AW-1:0]      op_d;
  arsm_pkg::cmp_res_t cmp;

  assign full     = fill_count == CW'(MAX_RANGES);
  assign in_stall = state != ST_LOAD;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && !full;
  assign out_free = !out_valid || !out_stall;
  assign joins    = cmp.a_lt_b || cmp.a_eq_b || cmp.a_touch_b;
  assign emit     = (state == ST_STEP) && out_free && (!found || (have_cur && !joins));

  arsm_store #(
    .DEPTH (MAX_RANGES),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (fill_count[IW-1:0]),
    .wr_start (range_start[AW-1:0]),
    .wr_end   (range_end[AW-1:0]),
    .rd_addr  (idx[IW-1:0]),
    .rd_start (rd_s),
    .rd_end   (rd_e)
  );

  always_comb begin
    if (state == ST_STEP) begin
      op_a = best_s;
      op_b = cur_e;
      op_c = best_e;
      op_d = cur_e;
    end else begin
      op_a = rd_s;
      op_b = best_s;
      op_c = rd_e;
      op_d = best_e;
    end
  end

  arsm_cmp #(
    .AW (AW)
  ) u_cmp (
    .op_a (op_a),
    .op_b (op_b),
    .op_c (op_c),
    .op_d (op_d),
    .op_p (prev_s),
    .res  (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      fill_count <= '0;
      dropped    <= 1'b0;
      idx        <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      have_prev  <= 1'b0;
      have_cur   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              fill_count <= fill_count + CW'(1);
            end
            if (is_last) begin
              idx   <= '0;
              found <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_vld && (!have_prev || cmp.a_gt_p)) begin
            if (!found || cmp.a_lt_b) begin
              best_s <= rd_s;
              best_e <= rd_e;
              found  <= 1'b1;
            end else if (cmp.a_eq_b && cmp.c_gt_d) begin
              best_e <= rd_e;
            end
          end
          rd_vld <= idx != fill_count;
          if (idx != fill_count) begin
            idx <= idx + CW'(1);
          end else if (!rd_vld) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (out_free) begin
            if (!found) begin
              merged_start <= FW'(cur_s);
              merged_end   <= FW'(cur_e);
              last_of_run  <= 1'b1;
              overflow     <= dropped;
              fill_count   <= '0;
              dropped      <= 1'b0;
              have_prev    <= 1'b0;
              have_cur     <= 1'b0;
              state        <= ST_LOAD;
            end else begin
              if (have_cur && !joins) begin
                merged_start <= FW'(cur_s);
                merged_end   <= FW'(cur_e);
                last_of_run  <= 1'b0;
                overflow     <= dropped;
                cur_s        <= best_s;
                cur_e        <= best_e;
              end else if (have_cur) begin
                if (cmp.c_gt_d) begin
                  cur_e <= best_e;
                end
              end else begin
                cur_s <= best_s;
                cur_e <= best_e;
              end
              have_cur  <= 1'b1;
              prev_s    <= best_s;
              have_prev <= 1'b1;
              idx       <= '0;
              found     <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/arsm_checker.sv -----
// Port-level checker for the address range sort and merge block, with its bind.
// Depends on address_range_sort_merge_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "address_range_sort_merge_assert.svh"

module arsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] range_start,
  input logic [31:0] range_end,
  input logic        is_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] merged_start,
  input logic [31:0] merged_end,
  input logic        last_of_run,
  input logic        overflow
);

  `ARSM_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && is_last, in_stall, "input open after last range")
  `ARSM_ASSERT_NEXT(a_load_continues, in_valid && !in_stall && !is_last, !in_stall, "input closed mid-set")
  `ARSM_ASSERT_NOW(a_partial_while_busy, out_valid && !last_of_run, in_stall, "input open before final result")
  `ARSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(merged_start) && $stable(merged_end) && $stable(last_of_run) && $stable(overflow), "stalled result changed")

endmodule

bind address_range_sort_merge arsm_checker u_arsm_checker (.*);
